### src/assert_macros.svh
// Assertion macros shared by the queue RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define DEQ_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: check failed");

// Check that an antecedent is followed by a consequent in the next cycle.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: sequence check failed");

`endif

### src/deq_pkg.sv
// Package with transaction types, operation and status codes for the queue.
package deq_pkg;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] push_value;
    logic [7:0]         position;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [8:0]         count_now;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the incoming command
    logic exec;   // update pointers, access the store, load the response
    logic fill;   // move store read data into the response
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic read_hit;  // captured command is a read inside the held range
  } sts_t;

endpackage

### src/deq_ctrl.sv
// Sequencing state machine for the queue: handshakes and datapath commands.
`include "assert_macros.svh"

module deq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  deq_pkg::sts_t sts,
  output deq_pkg::ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_RDWAIT = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = sts.read_hit ? S_RDWAIT : S_RESP;
      end
      S_RDWAIT: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!rsp_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = rst || (state != S_IDLE);
  assign rsp_valid = (state == S_RESP);
  assign ctl.load  = (state == S_IDLE) && cmd_valid && !rst;
  assign ctl.exec  = (state == S_EXEC);
  assign ctl.fill  = (state == S_RDWAIT);

  `DEQ_ASSERT_NEXT(a_accept_exec, cmd_valid && !cmd_stall, state == S_EXEC)
  `DEQ_ASSERT_NEXT(a_hit_waits, ctl.exec && sts.read_hit, ctl.fill && !rsp_valid)

endmodule

### src/deq_dpath.sv
// Queue datapath: command register, pointers, circular store, response register.
`include "assert_macros.svh"

module deq_dpath #(
  parameter int DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  deq_pkg::cmd_t cmd,
  input  deq_pkg::ctl_t ctl,
  output deq_pkg::sts_t sts,
  output deq_pkg::rsp_t rsp
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  deq_pkg::cmd_t cmd_q;
  deq_pkg::rsp_t rsp_q;

  logic [PW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data;

  logic          we, re;
  logic [PW-1:0] addr;
  logic [1:0]    status;
  logic          full, empty, hit;
  logic [CW+7:0] pos_wide;
  logic [CW+7:0] cnt_cmp;
  logic [CW+8:0] cnt_wide;
  logic [PW-1:0] front_dec, front_inc;

  // Add two in-range indexes and fold back into the store.
  function automatic logic [PW-1:0] wrap(input logic [PW-1:0] base,
                                         input logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PW+1)'(DEPTH)) sum = sum - (PW+1)'(DEPTH);
    return sum[PW-1:0];
  endfunction

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pos_wide  = {{CW{1'b0}}, cmd_q.position};
  assign cnt_cmp   = {8'd0, count};
  assign hit       = (cmd_q.operation == deq_pkg::OP_READ) && (pos_wide < cnt_cmp);
  assign front_dec = (front == '0) ? PW'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == PW'(DEPTH - 1)) ? '0 : front + 1'b1;

  always_comb begin
    status     = deq_pkg::ST_OK;
    count_next = count;
    front_next = front;
    we         = 1'b0;
    re         = 1'b0;
    addr       = front;
    case (cmd_q.operation)
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          we         = 1'b1;
          addr       = wrap(front, count[PW-1:0]);
          count_next = count + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          we         = 1'b1;
          addr       = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - 1'b1;
        end
      end
      deq_pkg::OP_READ: begin
        if (!hit) begin
          status = deq_pkg::ST_RANGE;
        end else begin
          re   = 1'b1;
          addr = wrap(front, pos_wide[PW-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_wide = {9'd0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (ctl.exec) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) cmd_q <= cmd;
    if (ctl.exec) begin
      rsp_q.read_value <= '0;
      rsp_q.status     <= status;
      rsp_q.count_now  <= cnt_wide[8:0];
    end else if (ctl.fill) begin
      rsp_q.read_value <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && we) mem[addr] <= cmd_q.push_value;
    if (ctl.exec && re) rd_data <= mem[addr];
  end

  assign sts.read_hit = hit;
  assign rsp          = rsp_q;

  `DEQ_ASSERT(a_count_bound, count <= CW'(DEPTH))
  `DEQ_ASSERT(a_front_bound, {1'b0, front} < (PW+1)'(DEPTH))
  `DEQ_ASSERT_NEXT(a_read_keeps_count, ctl.exec && hit, count == $past(count))

endmodule

### src/double_ended_queue_indexed.sv
// Top level of the indexed double-ended queue: controller plus datapath.
// Usage:
//   The command channel (cmd_valid, cmd_stall, cmd) carries one operation per
//   transaction: push back, push front, pop back, pop front, or read the entry
//   at a position counted from the front. A transaction is taken at a rising
//   edge with cmd_valid high and cmd_stall low.
//   The response channel (rsp_valid, rsp_stall, rsp) returns exactly one
//   transaction per command: the value read (zero unless a good read), a
//   status code and the entry count after the operation.
//   Timing: rsp_valid rises once the command has passed the execute state and,
//   for a good read only, the store-read state; the extra step for a good read
//   is the store's read register. A new command is taken only after the
//   response has been taken. The controller handles one command at a time:
//   capture, execute, (store read), respond.
//   Stall: while rsp_stall is high the response holds and no new command is
//   taken. Reset: the queue comes up empty with the front pointer at zero;
//   the store itself is not cleared, since only written entries are readable.
//   A push when full, a pop when empty and a read past the count change
//   nothing and are flagged in the status.
module double_ended_queue_indexed #(
  parameter int DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  deq_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output deq_pkg::rsp_t rsp
);

  deq_pkg::ctl_t ctl;
  deq_pkg::sts_t sts;

  // Sequence the transaction and drive both handshakes.
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Hold the pointers, the circular store and the response register.
  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .ctl (ctl),
    .sts (sts),
    .rsp (rsp)
  );

endmodule
